// ----- hw/rtl/ncc_pkg.sv -----
package ncc_pkg;

    localparam int QUEUE_DEPTH   = 2;
    localparam int CORR_BITS     = 17;
    localparam int FRAC_BITS     = 16;
    localparam int SCALE_BITS    = 32;
    localparam int BIT_IDX_BITS  = $clog2(FRAC_BITS + 1);

    localparam logic [CORR_BITS-1:0] CORR_ONE = CORR_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic [CORR_BITS-1:0] correlation;
        logic                 degenerate;
        logic                 saturated;
    } ncc_result_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic almost_full;
    } ncc_qstat_t;

endpackage

// ----- hw/rtl/normalized_cross_correlation.sv -----
// Channel  Ports                                         Item
// input    s_valid s_ready s_pixel_a s_pixel_b s_last_pixel  one pixel pair
// output   m_valid m_ready m_correlation m_degenerate m_saturated  one result per image
//
// Pairs are taken one per cycle while s_ready is high; the products are registered first, then added into the sums.
// Each image's final sums wait in a two-entry queue for the result unit, which
// takes one image at a time: two 5-step 52-bit products, then 17 square-root trial
// steps, each through the ADD_X, ADD_P and CMP states; a degenerate image skips them.
// Input stalls only when the queue cannot hold another finished image.
// Reset is synchronous, active low, empties the sums and the queue and clears m_valid; result data is not reset.
module normalized_cross_correlation
    import ncc_pkg::*;
#(
    parameter int PIXEL_BITS      = 16,
    parameter int MAX_PIXELS_LOG2 = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_pixel_a,
    input  logic [15:0]          s_pixel_b,
    input  logic                 s_last_pixel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CORR_BITS-1:0] m_correlation,
    output logic                 m_degenerate,
    output logic                 m_saturated
);

    localparam int ACC_BITS = 2 * PIXEL_BITS + MAX_PIXELS_LOG2;
    localparam int QW       = 3 * ACC_BITS + 1;

    ncc_qstat_t    q_stat;
    logic          q_push, q_pop;
    logic [QW-1:0] q_push_data, q_pop_data;
    ncc_result_t   result;

    ncc_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_a    (s_pixel_a),
        .s_pixel_b    (s_pixel_b),
        .s_last_pixel (s_last_pixel),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_push_data  (q_push_data)
    );

    ncc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .q_stat    (q_stat)
    );

    ncc_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .result  (result)
    );

    assign m_correlation = result.correlation;
    assign m_degenerate  = result.degenerate;
    assign m_saturated   = result.saturated;

endmodule

// ----- hw/rtl/ncc_queue.sv -----
module ncc_queue
    import ncc_pkg::*;
#(
    parameter int WIDTH = 157,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output ncc_qstat_t       q_stat
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign q_stat.empty       = (count_reg == '0);
    assign q_stat.full        = (count_reg == CNT_BITS'(DEPTH));
    assign q_stat.almost_full = (count_reg >= CNT_BITS'(DEPTH - 1));
    assign do_push            = push && !q_stat.full;
    assign do_pop             = pop && !q_stat.empty;
    assign pop_data           = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/ncc_front.sv -----
module ncc_front
    import ncc_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int ACC_BITS   = 52
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_pixel_a,
    input  logic [15:0]           s_pixel_b,
    input  logic                  s_last_pixel,
    input  ncc_qstat_t            q_stat,
    output logic                  q_push,
    output logic [3*ACC_BITS:0]   q_push_data
);

    localparam int PW = 2 * PIXEL_BITS;

    logic                  p1_valid_reg, p1_valid_next;
    logic                  p1_last_reg;
    logic [PW-1:0]         p_ab_reg, p_aa_reg, p_bb_reg;
    logic [PIXEL_BITS-1:0] pix_a, pix_b;
    logic [ACC_BITS-1:0]   sab_reg, saa_reg, sbb_reg;
    logic [ACC_BITS-1:0]   sab_next, saa_next, sbb_next;
    logic                  ovf_reg, ovf_next;
    logic [ACC_BITS:0]     add_ab, add_aa, add_bb;
    logic                  ovf_now;

    function automatic logic [ACC_BITS:0] sat_add(input logic [ACC_BITS-1:0] acc,
                                                  input logic [PW-1:0]       v);
        logic [ACC_BITS:0] sum;
        sum = {1'b0, acc} + (ACC_BITS+1)'(v);
        if (sum[ACC_BITS]) begin
            sat_add = {1'b1, {ACC_BITS{1'b1}}};
        end else begin
            sat_add = sum;
        end
    endfunction

    assign pix_a         = s_pixel_a[PIXEL_BITS-1:0];
    assign pix_b         = s_pixel_b[PIXEL_BITS-1:0];
    assign s_ready       = !q_stat.full && !(p1_valid_reg && p1_last_reg && q_stat.almost_full);
    assign p1_valid_next = s_valid && s_ready;

    assign add_ab  = sat_add(sab_reg, p_ab_reg);
    assign add_aa  = sat_add(saa_reg, p_aa_reg);
    assign add_bb  = sat_add(sbb_reg, p_bb_reg);
    assign ovf_now = ovf_reg || add_ab[ACC_BITS] || add_aa[ACC_BITS] || add_bb[ACC_BITS];

    assign q_push      = p1_valid_reg && p1_last_reg;
    assign q_push_data = {ovf_now, add_ab[ACC_BITS-1:0], add_aa[ACC_BITS-1:0],
                          add_bb[ACC_BITS-1:0]};

    always_comb begin
        sab_next = sab_reg;
        saa_next = saa_reg;
        sbb_next = sbb_reg;
        ovf_next = ovf_reg;
        if (p1_valid_reg) begin
            if (p1_last_reg) begin
                sab_next = '0;
                saa_next = '0;
                sbb_next = '0;
                ovf_next = 1'b0;
            end else begin
                sab_next = add_ab[ACC_BITS-1:0];
                saa_next = add_aa[ACC_BITS-1:0];
                sbb_next = add_bb[ACC_BITS-1:0];
                ovf_next = ovf_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            sab_reg      <= '0;
            saa_reg      <= '0;
            sbb_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            sab_reg      <= sab_next;
            saa_reg      <= saa_next;
            sbb_reg      <= sbb_next;
            ovf_reg      <= ovf_next;
        end
        if (p1_valid_next) begin
            p1_last_reg <= s_last_pixel;
            p_ab_reg    <= PW'(pix_a) * PW'(pix_b);
            p_aa_reg    <= PW'(pix_a) * PW'(pix_a);
            p_bb_reg    <= PW'(pix_b) * PW'(pix_b);
        end
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("item pushed into a full queue");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_last_reg) |=>
        (sab_reg == '0 && saa_reg == '0 && sbb_reg == '0 && !ovf_reg))
        else $error("sums not cleared after last item");

endmodule

// ----- hw/rtl/ncc_back.sv -----
module ncc_back
    import ncc_pkg::*;
#(
    parameter int ACC_BITS = 52
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ncc_qstat_t          q_stat,
    input  logic [3*ACC_BITS:0] q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ncc_result_t         result
);

    localparam int H  = (ACC_BITS + 1) / 2;
    localparam int MW = 4 * H;
    localparam int WW = 2 * ACC_BITS + SCALE_BITS + 3;
    localparam logic [2:0] MUL_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SQ,
        ST_MUL_PROD,
        ST_INIT,
        ST_ADD_X,
        ST_ADD_P,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic                    m_valid_reg, m_valid_next;
    ncc_result_t             result_reg, result_next;
    logic [ACC_BITS-1:0]     saa_reg, saa_next, sbb_reg, sbb_next;
    logic                    ovf_reg, ovf_next;
    logic [ACC_BITS-1:0]     mul_x_reg, mul_x_next, mul_y_reg, mul_y_next;
    logic [2:0]              step_reg, step_next;
    logic [2*H-1:0]          pp_reg, pp_next;
    logic [MW-1:0]           mul_acc_reg, mul_acc_next, mul_sum, pp_wide, pp_shifted;
    logic [2*ACC_BITS-1:0]   sq_reg, sq_next, prod_reg, prod_next;
    logic [WW-1:0]           pk_reg, pk_next, xk_reg, xk_next;
    logic [WW-1:0]           y_reg, y_next, t_reg, t_next, n_val;
    logic [CORR_BITS-1:0]    q_reg, q_next, q_cand;
    logic [BIT_IDX_BITS-1:0] bit_reg, bit_next;
    logic [2*H-1:0]          x_ext, y_ext;
    logic [H-1:0]            x_part, y_part;
    logic [ACC_BITS-1:0]     in_sab, in_saa, in_sbb;
    logic                    in_ovf;

    assign in_sbb = q_data[ACC_BITS-1:0];
    assign in_saa = q_data[2*ACC_BITS-1:ACC_BITS];
    assign in_sab = q_data[3*ACC_BITS-1:2*ACC_BITS];
    assign in_ovf = q_data[3*ACC_BITS];

    assign x_ext  = (2*H)'(mul_x_reg);
    assign y_ext  = (2*H)'(mul_y_reg);
    assign x_part = step_reg[1] ? x_ext[2*H-1:H] : x_ext[H-1:0];
    assign y_part = step_reg[0] ? y_ext[2*H-1:H] : y_ext[H-1:0];

    assign pp_wide = MW'(pp_reg);
    assign mul_sum = mul_acc_reg + pp_shifted;
    assign n_val   = {{(WW-2*ACC_BITS-SCALE_BITS){1'b0}}, sq_reg, {SCALE_BITS{1'b0}}};
    assign q_cand  = q_reg | (CORR_BITS'(1) << bit_reg);

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    always_comb begin
        case (step_reg)
            3'd1:    pp_shifted = pp_wide;
            3'd2:    pp_shifted = pp_wide << H;
            3'd3:    pp_shifted = pp_wide << H;
            3'd4:    pp_shifted = pp_wide << (2 * H);
            default: pp_shifted = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        saa_next     = saa_reg;
        sbb_next     = sbb_reg;
        ovf_next     = ovf_reg;
        mul_x_next   = mul_x_reg;
        mul_y_next   = mul_y_reg;
        step_next    = step_reg;
        pp_next      = pp_reg;
        mul_acc_next = mul_acc_reg;
        sq_next      = sq_reg;
        prod_next    = prod_reg;
        pk_next      = pk_reg;
        xk_next      = xk_reg;
        y_next       = y_reg;
        t_next       = t_reg;
        q_next       = q_reg;
        bit_next     = bit_reg;
        q_pop        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop        = 1'b1;
                    ovf_next     = in_ovf;
                    saa_next     = in_saa;
                    sbb_next     = in_sbb;
                    mul_x_next   = in_sab;
                    mul_y_next   = in_sab;
                    mul_acc_next = '0;
                    step_next    = '0;
                    if (in_saa == '0 || in_sbb == '0) begin
                        result_next  = '{correlation: CORR_ONE, degenerate: 1'b1,
                                         saturated: in_ovf};
                        m_valid_next = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        state_next = ST_MUL_SQ;
                    end
                end
            end
            ST_MUL_SQ, ST_MUL_PROD: begin
                pp_next      = (2*H)'(x_part) * (2*H)'(y_part);
                mul_acc_next = mul_sum;
                step_next    = step_reg + 1'b1;
                if (step_reg == MUL_LAST) begin
                    step_next    = '0;
                    mul_acc_next = '0;
                    if (state_reg == ST_MUL_SQ) begin
                        sq_next    = mul_sum[2*ACC_BITS-1:0];
                        mul_x_next = saa_reg;
                        mul_y_next = sbb_reg;
                        state_next = ST_MUL_PROD;
                    end else begin
                        prod_next  = mul_sum[2*ACC_BITS-1:0];
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                pk_next    = {{(WW-2*ACC_BITS-SCALE_BITS){1'b0}}, prod_reg,
                              {SCALE_BITS{1'b0}}};
                xk_next    = '0;
                y_next     = '0;
                q_next     = '0;
                bit_next   = BIT_IDX_BITS'(FRAC_BITS);
                state_next = ST_ADD_X;
            end
            ST_ADD_X: begin
                t_next     = y_reg + xk_reg;
                state_next = ST_ADD_P;
            end
            ST_ADD_P: begin
                t_next     = t_reg + pk_reg;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (!q_reg[FRAC_BITS] && t_reg <= n_val) begin
                    y_next  = t_reg;
                    q_next  = q_cand;
                    xk_next = (xk_reg >> 1) + pk_reg;
                end else begin
                    xk_next = xk_reg >> 1;
                end
                pk_next = pk_reg >> 2;
                if (bit_reg == '0) begin
                    result_next  = '{correlation: q_next, degenerate: 1'b0,
                                     saturated: ovf_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_ADD_X;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        result_reg  <= result_next;
        saa_reg     <= saa_next;
        sbb_reg     <= sbb_next;
        ovf_reg     <= ovf_next;
        mul_x_reg   <= mul_x_next;
        mul_y_reg   <= mul_y_next;
        step_reg    <= step_next;
        pp_reg      <= pp_next;
        mul_acc_reg <= mul_acc_next;
        sq_reg      <= sq_next;
        prod_reg    <= prod_next;
        pk_reg      <= pk_next;
        xk_reg      <= xk_next;
        y_reg       <= y_next;
        t_reg       <= t_next;
        q_reg       <= q_next;
        bit_reg     <= bit_next;
    end

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

    a_degen_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.degenerate) |-> (result_reg.correlation == CORR_ONE))
        else $error("degenerate item without unit correlation");

    a_corr_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (result_reg.correlation <= CORR_ONE))
        else $error("correlation above one");

    a_unit_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP && q_reg[FRAC_BITS]) |-> (q_reg[FRAC_BITS-1:0] == '0))
        else $error("fraction bits set beside the unit bit");

endmodule

// ----- sim/normalized_cross_correlation_tb.sv -----
`timescale 1ns / 1ps

module normalized_cross_correlation_tb;
    import ncc_pkg::*;

    localparam int PIXEL_BITS      = 16;
    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int ACC_BITS        = 2 * PIXEL_BITS + MAX_PIXELS_LOG2;
    localparam logic [63:0] ACC_MAX = (64'd1 << ACC_BITS) - 64'd1;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int RANDOM_PAIRS    = 610;

    typedef struct packed {
        logic [31:0] reps;
        logic [15:0] a;
        logic [15:0] b;
        logic        last;
    } pair_burst_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [15:0]          s_pixel_a = '0;
    logic [15:0]          s_pixel_b = '0;
    logic                 s_last_pixel = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CORR_BITS-1:0] m_correlation;
    logic                 m_degenerate;
    logic                 m_saturated;

    pair_burst_t  pending[$];
    ncc_result_t  expected_results[$];

    logic [63:0]  sum_ab = '0;
    logic [63:0]  sum_aa = '0;
    logic [63:0]  sum_bb = '0;
    logic         sums_clipped = 1'b0;

    logic         in_taken = 1'b0;
    int unsigned  burst_sent = 0;
    int unsigned  tx_idle_pct = 24;
    int unsigned  rx_idle_pct = 84;
    longint       queued_pairs = 0;
    longint       accepted_pairs = 0;
    int           idle_cycles = 0;
    int           mismatches = 0;

    normalized_cross_correlation dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_a     (s_pixel_a),
        .s_pixel_b     (s_pixel_b),
        .s_last_pixel  (s_last_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_correlation (m_correlation),
        .m_degenerate  (m_degenerate),
        .m_saturated   (m_saturated)
    );

    always #6 aclk = ~aclk;

    function automatic logic [CORR_BITS-1:0] ncc_q16(input logic [63:0] sab,
                                                     input logic [63:0] saa,
                                                     input logic [63:0] sbb);
        logic [191:0]         norm;
        logic [191:0]         target;
        logic [191:0]         trial;
        logic [33:0]          cand_sq;
        logic [CORR_BITS-1:0] q;
        logic [CORR_BITS-1:0] cand;
        int                   bit_i;
        norm   = 192'(saa) * 192'(sbb);
        target = (192'(sab) * 192'(sab)) << 32;
        q      = '0;
        for (bit_i = FRAC_BITS; bit_i >= 0; bit_i--) begin
            cand = q | (CORR_BITS'(1) << bit_i);
            if (cand <= CORR_ONE) begin
                cand_sq = 34'(cand) * 34'(cand);
                trial   = norm * 192'(cand_sq);
                if (trial <= target) begin
                    q = cand;
                end
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [63:0] v,
                                            inout logic clipped);
        if (acc > ACC_MAX - v) begin
            clipped = 1'b1;
            return ACC_MAX;
        end
        return acc + v;
    endfunction

    task automatic accumulate_pair(input logic [15:0] a, input logic [15:0] b,
                                   input logic last);
        logic [63:0] wa;
        logic [63:0] wb;
        logic        clipped;
        ncc_result_t res;
        wa      = 64'(a);
        wb      = 64'(b);
        clipped = sums_clipped;
        sum_ab  = sat_add(sum_ab, wa * wb, clipped);
        sum_aa  = sat_add(sum_aa, wa * wa, clipped);
        sum_bb  = sat_add(sum_bb, wb * wb, clipped);
        sums_clipped = clipped;
        if (last) begin
            if (sum_aa == 64'd0 || sum_bb == 64'd0) begin
                res.correlation = CORR_ONE;
                res.degenerate  = 1'b1;
            end else begin
                res.correlation = ncc_q16(sum_ab, sum_aa, sum_bb);
                res.degenerate  = 1'b0;
            end
            res.saturated = sums_clipped;
            expected_results.push_back(res);
            sum_ab       = '0;
            sum_aa       = '0;
            sum_bb       = '0;
            sums_clipped = 1'b0;
        end
    endtask

    task automatic push_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
                             input int unsigned reps = 1);
        pair_burst_t p;
        p.a    = a;
        p.b    = b;
        p.last = last;
        p.reps = reps;
        pending.push_back(p);
        queued_pairs += reps;
    endtask

    task automatic push_random_images(input int unsigned budget);
        int unsigned n;
        int unsigned len;
        int unsigned mode;
        int unsigned i;
        logic [15:0] a;
        logic [15:0] b;
        logic [16:0] tmp;
        n = 0;
        while (n < budget) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
            mode = $urandom_range(7);
            for (i = 0; i < len; i++) begin
                a = 16'($urandom);
                b = 16'($urandom);
                case (mode)
                    1: b = a;
                    2: b = 16'hFFFF - a;
                    3: begin
                        a = 16'($urandom_range(3));
                        b = 16'($urandom_range(3));
                    end
                    4: begin
                        if (len[0]) a = '0;
                        else b = '0;
                    end
                    5: begin
                        tmp = 17'(a) + 17'($urandom_range(64));
                        b   = tmp[16] ? 16'hFFFF : tmp[15:0];
                    end
                    6: b = a >> 1;
                    default: ;
                endcase
                push_pair(a, b, i == len - 1);
            end
            n += len;
        end
    endtask

    task automatic wait_all_accepted();
        while (accepted_pairs != queued_pairs) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
            if (s_valid && !in_taken) begin
                // hold the item until it is taken
            end else if (pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid      <= 1'b1;
                s_pixel_a    <= pending[0].a;
                s_pixel_b    <= pending[0].b;
                s_last_pixel <= pending[0].last;
                if (burst_sent + 1 >= pending[0].reps) begin
                    burst_sent = 0;
                    void'(pending.pop_front());
                end else begin
                    burst_sent = burst_sent + 1;
                end
            end else begin
                s_valid      <= 1'b0;
                s_pixel_a    <= 16'($urandom);
                s_pixel_b    <= 16'($urandom);
                s_last_pixel <= 1'($urandom_range(1));
            end
        end
    end

    always @(posedge aclk) begin
        ncc_result_t want;
        if (!aresetn) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result corr=%0d degen=%0d sat=%0d", $time,
                             m_correlation, m_degenerate, m_saturated);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_correlation !== want.correlation) begin
                        $display("%0t: correlation expected %0d actual %0d", $time,
                                 want.correlation, m_correlation);
                        mismatches++;
                    end
                    if (m_degenerate !== want.degenerate) begin
                        $display("%0t: degenerate expected %0d actual %0d", $time,
                                 want.degenerate, m_degenerate);
                        mismatches++;
                    end
                    if (m_saturated !== want.saturated) begin
                        $display("%0t: saturated expected %0d actual %0d", $time,
                                 want.saturated, m_saturated);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                accumulate_pair(s_pixel_a, s_pixel_b, s_last_pixel);
                accepted_pairs++;
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 24;
        rx_idle_pct = 84;
        push_pair(16'h0000, 16'h0000, 1'b1);
        push_pair(16'hFFFF, 16'hFFFF, 1'b1);
        push_pair(16'hFFFF, 16'h0000, 1'b1);
        push_pair(16'h0000, 16'hFFFF, 1'b1);
        push_pair(16'h0001, 16'h0001, 1'b1);
        push_pair(16'hFFFF, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'hFFFF, 1'b1);
        push_pair(16'h0001, 16'hFFFF, 1'b0);
        push_pair(16'hFFFF, 16'h0001, 1'b1);
        push_pair(16'hAAAA, 16'h5555, 1'b0);
        push_pair(16'h5555, 16'hAAAA, 1'b0);
        push_pair(16'hFFFF, 16'h0001, 1'b1);
        push_pair(16'h0001, 16'h0002, 1'b0);
        push_pair(16'h0003, 16'h0006, 1'b0);
        push_pair(16'h7FFF, 16'hFFFE, 1'b1);
        push_pair(16'h8000, 16'h7FFF, 1'b0);
        push_pair(16'h0000, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'h0000, 1'b1);
        push_pair(16'h0001, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'h0001, 1'b1);
        push_pair(16'h1234, 16'h1235, 1'b0);
        push_pair(16'hFFFF, 16'hFFFE, 1'b1);
        push_random_images(RANDOM_PAIRS);
        wait_all_accepted();

        tx_idle_pct = 84;
        rx_idle_pct = 24;
        push_random_images(RANDOM_PAIRS);
        wait_all_accepted();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random_images(RANDOM_PAIRS);
        wait_all_accepted();

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_queue.sv
hw/rtl/ncc_front.sv
hw/rtl/ncc_back.sv
hw/rtl/normalized_cross_correlation.sv
sim/normalized_cross_correlation_tb.sv
